// ----- hw/rtl/sts_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_pkg
// Shared types and constants of the sorted-table ternary search block.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int IDX_W       = 10;
    localparam int DATA_W      = 32;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(TABLE_DEPTH - 1);

    // x / 3 as (x * 683) >> 11, exact for x below 2048
    localparam logic [IDX_W-1:0] RECIP3       = IDX_W'(683);
    localparam int               RECIP3_SHIFT = 11;

    localparam logic [IDX_W-1:0] SEARCH_LOW_RESET  = '0;
    localparam logic [IDX_W-1:0] SEARCH_HIGH_RESET = IDX_W'(1023);

    typedef enum logic {
        OP_WRITE  = 1'b0,
        OP_SEARCH = 1'b1
    } op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SEARCH_LOW  = 2'd0,
        REG_SEARCH_HIGH = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CHECK,
        ST_REPORT
    } state_t;

    function automatic logic [IDX_W-1:0] div3(input logic [IDX_W-1:0] x);
        logic [2*IDX_W-1:0] prod;
        prod = (2*IDX_W)'(x) * (2*IDX_W)'(RECIP3);
        return IDX_W'(prod >> RECIP3_SHIFT);
    endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/sts_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sts_ram
// Generic RAM: one write port, two read ports, read data registered.
// ----------------------------------------------------------------------------
module sts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire                     aclk,
    input  wire                     wr_en,
    input  wire [$clog2(DEPTH)-1:0] wr_addr,
    input  wire [WIDTH-1:0]         wr_data,
    input  wire [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]        rd_data_a,
    input  wire [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]        rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule
`default_nettype wire

// ----- hw/rtl/sorted_table_ternary_search.sv -----
`default_nettype none
// Write item: written to the table when taken, no result.
// Search item: narrowing rounds, each a probe issue to the table RAM's
// registered read ports (ST_PROBE) and a compare (ST_CHECK), then a report
// (ST_REPORT); an empty window goes straight to the report. One item at a
// time: s_ready is high only in ST_IDLE. Reset sets search_low to 0 and
// search_high to 1023; table contents are not cleared.
// ----------------------------------------------------------------------------
// sorted_table_ternary_search
// Ternary search over a software-loaded ascending table held in RAM.
// ----------------------------------------------------------------------------
module sorted_table_ternary_search
    import sts_pkg::*;
(
    input  wire                    aclk,
    input  wire                    aresetn,

    input  wire                    cfg_valid,
    output logic                   cfg_ready,
    input  wire [CFG_IDX_W-1:0]    cfg_index,
    input  wire [CFG_DATA_W-1:0]   cfg_data,

    input  wire                    s_valid,
    output logic                   s_ready,
    input  wire                    s_operation,
    input  wire [IDX_W-1:0]        s_entry_index,
    input  wire signed [DATA_W-1:0] s_entry_value,
    input  wire signed [DATA_W-1:0] s_search_key,

    output logic                   m_valid,
    input  wire                    m_ready,
    output logic                   m_found,
    output logic [IDX_W-1:0]       m_found_index
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          search_low_reg, search_low_next;
    logic [IDX_W-1:0]          search_high_reg, search_high_next;
    logic [IDX_W-1:0]          lo_reg, lo_next;
    logic [IDX_W-1:0]          hi_reg, hi_next;
    logic [IDX_W-1:0]          p1_reg, p1_next;
    logic [IDX_W-1:0]          p2_reg, p2_next;
    logic signed [DATA_W-1:0]  key_reg, key_next;
    logic                      hit_reg, hit_next;
    logic [IDX_W-1:0]          where_reg, where_next;
    logic                      m_valid_reg, m_valid_next;
    logic                      m_found_reg, m_found_next;
    logic [IDX_W-1:0]          m_found_index_reg, m_found_index_next;

    logic [IDX_W-1:0]          third;
    logic [IDX_W-1:0]          probe1, probe2;
    logic [IDX_W-1:0]          high_clamped;
    logic                      in_xfer;
    logic                      ram_wr_en;
    logic [DATA_W-1:0]         rd_a, rd_b;
    logic signed [DATA_W-1:0]  v1, v2;

    assign cfg_ready     = 1'b1;
    assign in_xfer       = s_valid && s_ready;
    assign s_ready       = (state_reg == ST_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_found       = m_found_reg;
    assign m_found_index = m_found_index_reg;

    assign high_clamped = (search_high_reg > LAST_INDEX) ? LAST_INDEX : search_high_reg;

    // probe points of the current window
    assign third  = div3(hi_reg - lo_reg);
    assign probe1 = lo_reg + third;
    assign probe2 = hi_reg - third;

    assign ram_wr_en = in_xfer && (s_operation == OP_WRITE) && (s_entry_index <= LAST_INDEX);

    assign v1 = $signed(rd_a);
    assign v2 = $signed(rd_b);

    sts_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk      (aclk),
        .wr_en     (ram_wr_en),
        .wr_addr   (ADDR_W'(s_entry_index)),
        .wr_data   (s_entry_value),
        .rd_addr_a (ADDR_W'(probe1)),
        .rd_data_a (rd_a),
        .rd_addr_b (ADDR_W'(probe2)),
        .rd_data_b (rd_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            search_low_reg  <= SEARCH_LOW_RESET;
            search_high_reg <= SEARCH_HIGH_RESET;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            search_low_reg  <= search_low_next;
            search_high_reg <= search_high_next;
            m_valid_reg     <= m_valid_next;
        end
        lo_reg            <= lo_next;
        hi_reg            <= hi_next;
        p1_reg            <= p1_next;
        p2_reg            <= p2_next;
        key_reg           <= key_next;
        hit_reg           <= hit_next;
        where_reg         <= where_next;
        m_found_reg       <= m_found_next;
        m_found_index_reg <= m_found_index_next;
    end

    always_comb begin
        search_low_next  = search_low_reg;
        search_high_next = search_high_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_SEARCH_LOW:  search_low_next  = cfg_data[IDX_W-1:0];
                REG_SEARCH_HIGH: search_high_next = cfg_data[IDX_W-1:0];
                default:         ;
            endcase
        end
    end

    always_comb begin
        state_next         = state_reg;
        lo_next            = lo_reg;
        hi_next            = hi_reg;
        p1_next            = p1_reg;
        p2_next            = p2_reg;
        key_next           = key_reg;
        hit_next           = hit_reg;
        where_next         = where_reg;
        m_found_next       = m_found_reg;
        m_found_index_next = m_found_index_reg;
        // result leaves on a transfer
        m_valid_next       = m_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_xfer && (s_operation == OP_SEARCH)) begin
                    key_next   = s_search_key;
                    lo_next    = search_low_reg;
                    hi_next    = high_clamped;
                    hit_next   = 1'b0;
                    where_next = '0;
                    if (high_clamped < search_low_reg) begin
                        state_next = ST_REPORT;
                    end else begin
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_PROBE: begin
                p1_next    = probe1;
                p2_next    = probe2;
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                priority if (v1 == key_reg) begin
                    hit_next   = 1'b1;
                    where_next = p1_reg;
                    state_next = ST_REPORT;
                end else if (v2 == key_reg) begin
                    hit_next   = 1'b1;
                    where_next = p2_reg;
                    state_next = ST_REPORT;
                end else if (key_reg < v1) begin
                    // left third, empty once p1 is the low end
                    if (p1_reg == lo_reg) begin
                        state_next = ST_REPORT;
                    end else begin
                        hi_next    = p1_reg - IDX_W'(1);
                        state_next = ST_PROBE;
                    end
                end else if (key_reg > v2) begin
                    if (p2_reg == hi_reg) begin
                        state_next = ST_REPORT;
                    end else begin
                        lo_next    = p2_reg + IDX_W'(1);
                        state_next = ST_PROBE;
                    end
                end else begin
                    // middle third, empty unless p2 - p1 is at least 2
                    if ((p2_reg - p1_reg) < IDX_W'(2)) begin
                        state_next = ST_REPORT;
                    end else begin
                        lo_next    = p1_reg + IDX_W'(1);
                        hi_next    = p2_reg - IDX_W'(1);
                        state_next = ST_PROBE;
                    end
                end
            end
            ST_REPORT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next       = 1'b1;
                    m_found_next       = hit_reg;
                    m_found_index_next = where_reg;
                    state_next         = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire
